// ----- rtl/core/cascaded_pi_attitude_rate_defines.svh -----
// assertion macros for the cascaded pi attitude/rate controller
// used by the checker; expects clk and rst_n in scope
`ifndef CASCADED_PI_ATTITUDE_RATE_DEFINES_SVH
`define CASCADED_PI_ATTITUDE_RATE_DEFINES_SVH

// property checked only while out of reset
`define CPAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CPAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/cpar_pkg.sv -----
// package for the cascaded pi attitude/rate controller
// payload structs, register indexes and fixed-point constants; no dependencies
`default_nettype none

package cpar_pkg;

  // one input item
  typedef struct packed {
    logic signed [15:0] angle_measured;
    logic signed [15:0] rate_measured;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] angle_loop_out;
    logic signed [15:0] rate_loop_out;
  } out_item_t;

  // configuration register indexes
  localparam logic [2:0] REG_SETPOINT_ANGLE = 3'd0;
  localparam logic [2:0] REG_KP_ANGLE       = 3'd1;
  localparam logic [2:0] REG_KI_ANGLE       = 3'd2;
  localparam logic [2:0] REG_KP_RATE        = 3'd3;
  localparam logic [2:0] REG_KI_RATE        = 3'd4;

  // gain reset values, unsigned q3.12
  localparam logic [14:0] KP_ANGLE_RST = 15'd2744;
  localparam logic [14:0] KI_ANGLE_RST = 15'd123;
  localparam logic [14:0] KP_RATE_RST  = 15'd4592;
  localparam logic [14:0] KI_RATE_RST  = 15'd0;

  // rounding half lsb of q.24 products and the outer integral limit
  localparam logic signed [32:0] Q_HALF     = 33'sd2048;
  localparam logic signed [20:0] INT_LIM_HI = 21'sd4096;
  localparam logic signed [20:0] INT_LIM_LO = -21'sd4096;
  localparam logic signed [20:0] SAT_HI     = 21'sd32767;
  localparam logic signed [20:0] SAT_LO     = -21'sd32768;

endpackage

`default_nettype wire

// ----- rtl/core/cascaded_pi_attitude_rate.sv -----
// cascaded pi attitude/rate controller, top level
// uses cpar_pkg; one shared multiply-round unit under a small sequencer
//
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_data    | item in: measured angle and rate
//   out     | out_valid, out_stall, out_data | item out: both loop drives
//   cfg     | cfg_we, cfg_addr, cfg_wdata    | register write, no read-back
//
// an item is taken only in idle; work on it runs through four passes through
// the one 16x17 multiplier plus sum and saturate steps before the next is taken.
// the result waits in an output register; if it is still not taken when the
// next result is ready, the sequencer holds in its last step.
// rst_n (synchronous) clears sequencer, both integrals, setpoint; gains get reset values
`default_nettype none

module cascaded_pi_attitude_rate (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cpar_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cpar_pkg::out_item_t    out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [15:0]       cfg_wdata
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KIA  = 3'd1;
  localparam logic [2:0] ST_KPA  = 3'd2;
  localparam logic [2:0] ST_AOUT = 3'd3;
  localparam logic [2:0] ST_KIR  = 3'd4;
  localparam logic [2:0] ST_KPR  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // saturate a 21 bit sum to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > cpar_pkg::SAT_HI)      sat16 = 16'sh7fff;
    else if (v < cpar_pkg::SAT_LO) sat16 = -16'sh8000;
    else                           sat16 = v[15:0];
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic signed [15:0] setpoint_r;
  logic [14:0]        kp_angle_r, ki_angle_r, kp_rate_r, ki_rate_r;
  logic signed [13:0] ang_int_r, ang_int_nxt;
  logic signed [15:0] rate_int_r, rate_int_nxt;
  logic signed [16:0] err_r, err_nxt;
  logic signed [15:0] rate_meas_r, rate_meas_nxt;
  logic signed [15:0] a_out_r, a_out_nxt;
  logic signed [20:0] q_r, q_nxt;
  logic               out_valid_r, out_valid_nxt;
  cpar_pkg::out_item_t out_data_r, out_data_nxt;

  // shared multiply-round unit
  logic [14:0]        mul_gain;
  logic signed [32:0] mul_prod;
  logic signed [32:0] mul_rnd;
  logic signed [20:0] mul_q;

  // sums feeding the integrals and outputs
  logic signed [20:0] ang_sum, rate_sum, ang_int_sum, rate_int_sum;
  logic signed [15:0] a_sat;
  logic               in_acc, out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;

  // gain select: integral gain in KI steps, proportional gain in KP steps, zero otherwise
  always_comb begin
    case (state_r)
      ST_KIA:  mul_gain = ki_angle_r;
      ST_KPA:  mul_gain = kp_angle_r;
      ST_KIR:  mul_gain = ki_rate_r;
      ST_KPR:  mul_gain = kp_rate_r;
      default: mul_gain = '0;
    endcase
  end

  // product, round half up, arithmetic shift back to signed q8.12
  assign mul_prod = $signed({1'b0, mul_gain}) * err_r;
  assign mul_rnd  = mul_prod + cpar_pkg::Q_HALF;
  assign mul_q    = mul_rnd[32:12];

  assign ang_int_sum  = {{7{ang_int_r[13]}}, ang_int_r} + q_r;
  assign rate_int_sum = {{5{rate_int_r[15]}}, rate_int_r} + q_r;
  assign ang_sum      = {{7{ang_int_r[13]}}, ang_int_r} + q_r;
  assign rate_sum     = {{5{rate_int_r[15]}}, rate_int_r} + q_r;
  assign a_sat        = sat16(ang_sum);

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    ang_int_nxt   = ang_int_r;
    rate_int_nxt  = rate_int_r;
    err_nxt       = err_r;
    rate_meas_nxt = rate_meas_r;
    a_out_nxt     = a_out_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt = {setpoint_r[15], setpoint_r}
                  - {in_data.angle_measured[15], in_data.angle_measured};
          rate_meas_nxt = in_data.rate_measured;
          state_nxt     = ST_KIA;
        end
      end
      ST_KIA: begin
        q_nxt     = mul_q;
        state_nxt = ST_KPA;
      end
      ST_KPA: begin
        // clamp the outer integral to plus or minus one
        if (ang_int_sum > cpar_pkg::INT_LIM_HI)
          ang_int_nxt = cpar_pkg::INT_LIM_HI[13:0];
        else if (ang_int_sum < cpar_pkg::INT_LIM_LO)
          ang_int_nxt = cpar_pkg::INT_LIM_LO[13:0];
        else
          ang_int_nxt = ang_int_sum[13:0];
        q_nxt     = mul_q;
        state_nxt = ST_AOUT;
      end
      ST_AOUT: begin
        a_out_nxt = a_sat;
        err_nxt   = {a_sat[15], a_sat} - {rate_meas_r[15], rate_meas_r};
        state_nxt = ST_KIR;
      end
      ST_KIR: begin
        q_nxt     = mul_q;
        state_nxt = ST_KPR;
      end
      ST_KPR: begin
        rate_int_nxt = sat16(rate_int_sum);
        q_nxt        = mul_q;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        // load the output register once it is free
        if (!out_valid_r || out_acc) begin
          out_data_nxt.angle_loop_out = a_out_r;
          out_data_nxt.rate_loop_out  = sat16(rate_sum);
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a setpoint write restarts the outer integral
    if (cfg_we && cfg_addr == cpar_pkg::REG_SETPOINT_ANGLE) begin
      ang_int_nxt = '0;
    end
  end

  // control state, integrals and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ang_int_r   <= '0;
      rate_int_r  <= '0;
      setpoint_r  <= '0;
      kp_angle_r  <= cpar_pkg::KP_ANGLE_RST;
      ki_angle_r  <= cpar_pkg::KI_ANGLE_RST;
      kp_rate_r   <= cpar_pkg::KP_RATE_RST;
      ki_rate_r   <= cpar_pkg::KI_RATE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ang_int_r   <= ang_int_nxt;
      rate_int_r  <= rate_int_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          cpar_pkg::REG_SETPOINT_ANGLE: setpoint_r <= cfg_wdata;
          cpar_pkg::REG_KP_ANGLE:       kp_angle_r <= cfg_wdata[14:0];
          cpar_pkg::REG_KI_ANGLE:       ki_angle_r <= cfg_wdata[14:0];
          cpar_pkg::REG_KP_RATE:        kp_rate_r  <= cfg_wdata[14:0];
          cpar_pkg::REG_KI_RATE:        ki_rate_r  <= cfg_wdata[14:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    rate_meas_r <= rate_meas_nxt;
    a_out_r     <= a_out_nxt;
    q_r         <= q_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cpar_checker.sv -----
// port-level checker for the cascaded pi attitude/rate controller
// uses cpar_pkg and the assertion macros; bound to the top level below
`default_nettype none
`include "cascaded_pi_attitude_rate_defines.svh"

module cpar_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire cpar_pkg::out_item_t out_data
);

  // result offered but held off by the receiver
  logic out_held;
  assign out_held = out_valid && out_stall;

  // reset empties the output register
  `CPAR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "out_valid set after reset")

  // an accepted item keeps the block busy
  `CPAR_ASSERT(a_busy_after_acc, (in_valid && !in_stall) |=> in_stall, "ready right after accept")

  // a result only appears at the end of work on an item
  `CPAR_ASSERT(a_res_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

  // a waiting result holds its value
  `CPAR_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind cascaded_pi_attitude_rate cpar_checker u_cpar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
